// ----- sv/ihex_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ihex_pkg
// Shared types, character codes and the hex digit decoder of the Intel HEX
// record parser.
// ---------------------------------------------------------------------------
package ihex_pkg;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_OK     = 2'd1,
        KIND_BADSUM = 2'd2,
        KIND_BADHEX = 2'd3
    } t_kind;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF    = 8'h66;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_digit;

    // Decodes one ASCII hex digit; ok is low for any other character.
    function automatic t_digit hex_digit(input logic [7:0] ch);
        t_digit     d;
        logic [7:0] diff;
        d    = '{ok: 1'b0, value: 4'd0};
        diff = 8'd0;
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            diff = ch - CHAR_ZERO;
            d    = '{ok: 1'b1, value: diff[3:0]};
        end else if (ch >= CHAR_LA && ch <= CHAR_LF) begin
            diff = ch - CHAR_LA + 8'd10;
            d    = '{ok: 1'b1, value: diff[3:0]};
        end else if (ch >= CHAR_UA && ch <= CHAR_UF) begin
            diff = ch - CHAR_UA + 8'd10;
            d    = '{ok: 1'b1, value: diff[3:0]};
        end
        return d;
    endfunction

endpackage
`default_nettype wire

// ----- sv/intel_hex_record_parser_top.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// Intel HEX record parser
// Parses ASCII Intel HEX text one character per transaction and reports
// data bytes with their addresses plus a per-record status.
// ---------------------------------------------------------------------------
//  Channel  Dir  Handshake          Payload
//  input    in   i_valid / o_stall  i_character[7:0]
//  result   out  o_valid / i_stall  o_kind, o_address, o_data_byte,
//                                   o_record_type, o_record_count
//
//  One character is taken per cycle while o_stall is low; each accepted
//  character waits in the input register, and any result it produces is
//  then loaded into the result register.
//  The parse state updates in one pass between the two registers.
//  A stall on the result side holds the result register and then the input
//  register; o_stall rises only while the input register is occupied.
//  Synchronous reset clears the parse state and both valid flags; after a
//  bad checksum or a bad hex digit the parser ignores input until reset.
// ---------------------------------------------------------------------------
module intel_hex_record_parser_top
    import ihex_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_character,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_kind,
    output logic [15:0]      o_address,
    output logic [7:0]       o_data_byte,
    output logic [7:0]       o_record_type,
    output logic [7:0]       o_record_count
);

    typedef enum logic [2:0] {
        PH_HUNT, PH_COUNT, PH_ADDR, PH_TYPE, PH_DATA, PH_CHECK
    } t_phase;

    // Input register.
    logic        r_in_valid;
    logic [7:0]  r_in_char;

    // Parse state.
    t_phase      r_phase,   n_phase;
    logic        r_hi_pend, n_hi_pend;
    logic [3:0]  r_hi_nib,  n_hi_nib;
    logic        r_addr_lo, n_addr_lo;
    logic [7:0]  r_count,   n_count;
    logic [7:0]  r_remain,  n_remain;
    logic [15:0] r_start,   n_start;
    logic [15:0] r_next,    n_next;
    logic [7:0]  r_type,    n_type;
    logic [7:0]  r_sum,     n_sum;
    logic        r_halted,  n_halted;

    // Result register.
    logic        r_out_valid;
    t_kind       r_kind,    n_kind;
    logic [15:0] r_addr,    n_addr;
    logic [7:0]  r_data,    n_data;
    logic [7:0]  r_rtype,   n_rtype;
    logic [7:0]  r_rcount,  n_rcount;

    logic        proc_go;
    logic        proc_fire;
    logic        emit;
    t_digit      dig;
    logic [7:0]  byte_val;
    logic [7:0]  sum_add;

    assign proc_go   = !r_out_valid || !i_stall;
    assign proc_fire = r_in_valid && proc_go;
    assign o_stall   = r_in_valid && !proc_go;

    assign dig      = hex_digit(r_in_char);
    assign byte_val = {r_hi_nib, dig.value};
    assign sum_add  = r_sum + byte_val;

    always_comb begin
        n_phase   = r_phase;
        n_hi_pend = r_hi_pend;
        n_hi_nib  = r_hi_nib;
        n_addr_lo = r_addr_lo;
        n_count   = r_count;
        n_remain  = r_remain;
        n_start   = r_start;
        n_next    = r_next;
        n_type    = r_type;
        n_sum     = r_sum;
        n_halted  = r_halted;
        emit      = 1'b0;
        n_kind    = KIND_DATA;
        n_addr    = r_start;
        n_data    = 8'd0;
        n_rtype   = r_type;
        n_rcount  = r_count;

        if (proc_fire && !r_halted && r_in_char >= CHAR_SPACE) begin
            if (r_phase == PH_HUNT) begin
                if (r_in_char == CHAR_COLON) begin
                    n_phase   = PH_COUNT;
                    n_hi_pend = 1'b0;
                    n_hi_nib  = 4'd0;
                    n_addr_lo = 1'b0;
                    n_count   = 8'd0;
                    n_remain  = 8'd0;
                    n_start   = 16'd0;
                    n_next    = 16'd0;
                    n_type    = 8'd0;
                    n_sum     = 8'd0;
                end
            end else if (!dig.ok) begin
                n_halted = 1'b1;
                n_phase  = PH_HUNT;
                emit     = 1'b1;
                n_kind   = KIND_BADHEX;
            end else if (!r_hi_pend) begin
                n_hi_nib  = dig.value;
                n_hi_pend = 1'b1;
            end else begin
                n_hi_pend = 1'b0;
                n_sum     = sum_add;
                unique case (r_phase)
                    PH_COUNT: begin
                        n_count   = byte_val;
                        n_remain  = byte_val;
                        n_addr_lo = 1'b0;
                        n_phase   = PH_ADDR;
                    end
                    PH_ADDR: begin
                        if (!r_addr_lo) begin
                            n_start   = {byte_val, 8'd0};
                            n_addr_lo = 1'b1;
                        end else begin
                            n_start   = {r_start[15:8], byte_val};
                            n_next    = {r_start[15:8], byte_val};
                            n_addr_lo = 1'b0;
                            n_phase   = PH_TYPE;
                        end
                    end
                    PH_TYPE: begin
                        n_type  = byte_val;
                        n_phase = (r_remain != 8'd0) ? PH_DATA : PH_CHECK;
                    end
                    PH_DATA: begin
                        emit     = 1'b1;
                        n_kind   = KIND_DATA;
                        n_addr   = r_next;
                        n_data   = byte_val;
                        n_next   = r_next + 16'd1;
                        n_remain = r_remain - 8'd1;
                        if (r_remain == 8'd1) begin
                            n_phase = PH_CHECK;
                        end
                    end
                    PH_CHECK: begin
                        n_phase = PH_HUNT;
                        emit    = 1'b1;
                        if (sum_add == 8'd0) begin
                            n_kind = KIND_OK;
                        end else begin
                            n_halted = 1'b1;
                            n_kind   = KIND_BADSUM;
                        end
                    end
                    default: begin
                        n_phase = PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_HUNT;
            r_hi_pend   <= 1'b0;
            r_hi_nib    <= 4'd0;
            r_addr_lo   <= 1'b0;
            r_count     <= 8'd0;
            r_remain    <= 8'd0;
            r_start     <= 16'd0;
            r_next      <= 16'd0;
            r_type      <= 8'd0;
            r_sum       <= 8'd0;
            r_halted    <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            r_phase   <= n_phase;
            r_hi_pend <= n_hi_pend;
            r_hi_nib  <= n_hi_nib;
            r_addr_lo <= n_addr_lo;
            r_count   <= n_count;
            r_remain  <= n_remain;
            r_start   <= n_start;
            r_next    <= n_next;
            r_type    <= n_type;
            r_sum     <= n_sum;
            r_halted  <= n_halted;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_char <= i_character;
        end
        if (emit) begin
            r_kind   <= n_kind;
            r_addr   <= n_addr;
            r_data   <= n_data;
            r_rtype  <= n_rtype;
            r_rcount <= n_rcount;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_kind;
    assign o_address      = r_addr;
    assign o_data_byte    = r_data;
    assign o_record_type  = r_rtype;
    assign o_record_count = r_rcount;

    // Once halted, the parser stays halted until reset.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag cleared without reset");

    // A halted parser never loads a new result.
    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> !emit)
        else $error("result produced while halted");

    // Status results carry a zero data byte.
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind != KIND_DATA) |-> (r_data == 8'd0))
        else $error("status result with nonzero data byte");

    // A stalled result is never overwritten by a new one.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !emit)
        else $error("result register overwritten while stalled");

    // The input stage only backs up while the result side is blocked.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_out_valid && i_stall))
        else $error("input stalled without a blocked result");

endmodule
`default_nettype wire
